@@ src/peh_pkg.sv @@
// Shared types and constants for the particle energy histogram core.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package peh_pkg;

  localparam int POSITION_BINS = 16;
  localparam int ENERGY_BINS   = 256;
  localparam int PBIN_W        = $clog2(POSITION_BINS);
  localparam int EBIN_W        = $clog2(ENERGY_BINS);
  localparam int CELL_W        = PBIN_W + EBIN_W;
  localparam int CELLS         = POSITION_BINS * ENERGY_BINS;
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = $clog2(QDEPTH);

  // energies are below 2^56; an edge above this lies beyond all of them
  localparam logic [63:0] EDGE_CAP = 64'h0100_0000_0000_0000;

  localparam logic [2:0] REG_POSITION_MINIMUM   = 3'd0;
  localparam logic [2:0] REG_POSITION_BIN_WIDTH = 3'd1;
  localparam logic [2:0] REG_ENERGY_FIRST_EDGE  = 3'd2;
  localparam logic [2:0] REG_ENERGY_STEP        = 3'd3;
  localparam logic [2:0] REG_ENERGY_RATIO       = 3'd4;
  localparam logic [2:0] REG_LOG_MODE           = 3'd5;
  localparam logic [2:0] REG_ELECTRON_FACTOR    = 3'd6;
  localparam logic [2:0] REG_ION_FACTOR         = 3'd7;

  typedef enum logic [1:0] {
    ACT_BIN   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    action_t            action;
    logic signed [31:0] position;
    logic signed [23:0] electron_vel_x;
    logic signed [23:0] electron_vel_y;
    logic signed [23:0] electron_vel_z;
    logic signed [23:0] ion_vel_x;
    logic signed [23:0] ion_vel_y;
    logic signed [23:0] ion_vel_z;
    logic [3:0]         read_position_bin;
    logic [7:0]         read_energy_bin;
  } in_item_t;

  typedef struct packed {
    logic [31:0] electron_count;
    logic [31:0] ion_count;
    logic        position_outside;
    logic        electron_binned;
    logic        ion_binned;
  } out_item_t;

  typedef struct packed {
    logic [31:0] position_minimum;
    logic [31:0] position_bin_width;
    logic [63:0] energy_first_edge;
    logic [63:0] energy_step;
    logic [31:0] energy_ratio;
    logic        log_mode;
    logic [31:0] electron_energy_factor;
    logic [31:0] ion_energy_factor;
  } cfg_t;

  // classified work handed from front to back
  typedef struct packed {
    action_t           action;
    logic              outside;
    logic [PBIN_W-1:0] pbin;
    logic [55:0]       e_energy;
    logic [55:0]       i_energy;
    logic [3:0]        read_position_bin;
    logic [7:0]        read_energy_bin;
  } cmd_t;

  typedef struct packed {
    logic push;
  } qctl_t;

endpackage

@@ src/particle_energy_histogram_core.sv @@
// Top level of the particle energy histogram: configuration registers,
// front end, command queue and back end. Depends on peh_pkg and all peh_ modules.
`timescale 1ns / 1ps

// After reset the block sweeps both 4096-entry histogram memories to zero, one
// cell a cycle, and takes no beat meanwhile; configuration writes are taken
// throughout. A particle beat passes the front end (position subtract steps,
// then squaring and multiply steps) and then, in the back end, one edge walk
// per species: one step per energy bin passed, in log mode through two multiply
// states and an add state, plus a read and an increment state per counter
// update. A clear beat sweeps both memories, a read beat reads one cell. The
// two-entry queue lets the front end take and classify the next beat while the
// back end works.
module particle_energy_histogram_core import peh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  in_item_t    item,
  output logic        result_valid,
  input  logic        result_stall,
  output out_item_t   result,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_t  cfg;
  qctl_t qctl;
  cmd_t  push_cmd, head;
  logic  q_full, q_valid, q_pop, init_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.position_minimum       <= 32'd0;
      cfg.position_bin_width     <= 32'd6554;
      cfg.energy_first_edge      <= 64'd0;
      cfg.energy_step            <= 64'd8388608;
      cfg.energy_ratio           <= 32'd53234298;
      cfg.log_mode               <= 1'b0;
      cfg.electron_energy_factor <= 32'd0;
      cfg.ion_energy_factor      <= 32'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_POSITION_MINIMUM:   cfg.position_minimum       <= cfg_data[31:0];
        REG_POSITION_BIN_WIDTH: cfg.position_bin_width     <= cfg_data[31:0];
        REG_ENERGY_FIRST_EDGE:  cfg.energy_first_edge      <= cfg_data;
        REG_ENERGY_STEP:        cfg.energy_step            <= cfg_data;
        REG_ENERGY_RATIO:       cfg.energy_ratio           <= cfg_data[31:0];
        REG_LOG_MODE:           cfg.log_mode               <= cfg_data[0];
        REG_ELECTRON_FACTOR:    cfg.electron_energy_factor <= cfg_data[31:0];
        REG_ION_FACTOR:         cfg.ion_energy_factor      <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  peh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cfg        (cfg),
    .hold       (init_busy),
    .qctl_o     (qctl),
    .q_full     (q_full),
    .push_cmd   (push_cmd)
  );

  peh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .qctl     (qctl),
    .push_cmd (push_cmd),
    .full     (q_full),
    .valid    (q_valid),
    .pop      (q_pop),
    .head     (head)
  );

  peh_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .cmd          (head),
    .cfg          (cfg),
    .init_busy    (init_busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    qctl.push |-> !q_full)
    else $error("command queue written while full");

  a_outside_unbinned: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.position_outside |->
      !result.electron_binned && !result.ion_binned)
    else $error("particle outside the position range was energy-binned");

  a_init_hold: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> item_stall)
    else $error("beat taken during the reset sweep");

endmodule

@@ src/peh_front.sv @@
// Front end: accepts beats, bins the position and forms both energies.
// Depends on peh_pkg.
`timescale 1ns / 1ps

module peh_front import peh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_stall,
  input  in_item_t item,
  input  cfg_t     cfg,
  input  logic     hold,
  output qctl_t    qctl_o,
  input  logic     q_full,
  output cmd_t     push_cmd
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_POS  = 5'b00010,
    F_SQR  = 5'b00100,
    F_MUL  = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  fstate_t           state;
  in_item_t          cur;
  logic [31:0]       rem;
  logic [PBIN_W-1:0] pcount;
  logic              outside;
  logic [2:0]        step;
  logic [47:0]       sq;
  logic [47:0]       sum_e, sum_i;
  logic [55:0]       prod;
  logic [55:0]       en_e, en_i;

  logic               accept;
  logic [32:0]        diff;
  logic signed [23:0] vel;
  logic signed [47:0] sq_next;
  logic [47:0]        msum;
  logic [23:0]        half;
  logic [31:0]        fac;
  logic [55:0]        prod_next;
  logic [2:0]         mstep;

  assign item_stall = (state != F_IDLE) || hold;
  assign accept     = item_valid && !item_stall;
  assign diff = {item.position[31], item.position}
              - {cfg.position_minimum[31], cfg.position_minimum};

  always_comb begin
    case (step)
      3'd0:    vel = cur.electron_vel_x;
      3'd1:    vel = cur.electron_vel_y;
      3'd2:    vel = cur.electron_vel_z;
      3'd3:    vel = cur.ion_vel_x;
      3'd4:    vel = cur.ion_vel_y;
      3'd5:    vel = cur.ion_vel_z;
      default: vel = '0;
    endcase
  end
  assign sq_next = vel * vel;

  // 48 x 32 energy product taken as two 24 x 32 halves
  assign msum      = step[1] ? sum_i : sum_e;
  assign half      = step[0] ? msum[47:24] : msum[23:0];
  assign fac       = step[1] ? cfg.ion_energy_factor : cfg.electron_energy_factor;
  assign prod_next = 56'(half) * 56'(fac);
  assign mstep     = step - 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            cur     <= item;
            rem     <= diff[31:0];
            pcount  <= '0;
            outside <= 1'b0;
            if (item.action == ACT_BIN) begin
              if (diff[32] || cfg.position_bin_width == '0) begin
                outside <= 1'b1;
                state   <= F_PUSH;
              end else begin
                state <= F_POS;
              end
            end else begin
              state <= F_PUSH;
            end
          end
        end
        F_POS: begin
          if (rem < cfg.position_bin_width) begin
            step  <= '0;
            sum_e <= '0;
            sum_i <= '0;
            state <= F_SQR;
          end else if (pcount == PBIN_W'(POSITION_BINS - 1)) begin
            outside <= 1'b1;
            state   <= F_PUSH;
          end else begin
            rem    <= rem - cfg.position_bin_width;
            pcount <= pcount + 1'b1;
          end
        end
        F_SQR: begin
          sq <= sq_next;
          if (step != 3'd0) begin
            if (step <= 3'd3) sum_e <= sum_e + sq;
            else              sum_i <= sum_i + sq;
          end
          if (step == 3'd6) begin
            step  <= '0;
            state <= F_MUL;
          end else begin
            step <= step + 1'b1;
          end
        end
        F_MUL: begin
          prod <= prod_next;
          case (mstep)
            3'd0:    en_e <= {24'd0, prod[55:24]};
            3'd1:    en_e <= en_e + prod;
            3'd2:    en_i <= {24'd0, prod[55:24]};
            3'd3:    en_i <= en_i + prod;
            default: ;
          endcase
          if (step == 3'd4) state <= F_PUSH;
          step <= step + 1'b1;
        end
        F_PUSH: begin
          if (!q_full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign qctl_o.push = (state == F_PUSH) && !q_full;

  assign push_cmd.action            = cur.action;
  assign push_cmd.outside           = outside;
  assign push_cmd.pbin              = pcount;
  assign push_cmd.e_energy          = en_e;
  assign push_cmd.i_energy          = en_i;
  assign push_cmd.read_position_bin = cur.read_position_bin;
  assign push_cmd.read_energy_bin   = cur.read_energy_bin;

endmodule

@@ src/peh_queue.sv @@
// Two-entry command queue between front end and back end.
// Depends on peh_pkg.
`timescale 1ns / 1ps

module peh_queue import peh_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  qctl_t qctl,
  input  cmd_t  push_cmd,
  output logic  full,
  output logic  valid,
  input  logic  pop,
  output cmd_t  head
);

  cmd_t              store [QDEPTH];
  logic [QPTR_W-1:0] wp, rp;
  logic [QPTR_W:0]   count;

  assign full  = count == (QPTR_W + 1)'(QDEPTH);
  assign valid = count != '0;
  assign head  = store[rp];

  always_ff @(posedge clk) begin
    if (qctl.push) store[wp] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (qctl.push) wp <= wp + 1'b1;
      if (pop)       rp <= rp + 1'b1;
      count <= count + (QPTR_W + 1)'(qctl.push) - (QPTR_W + 1)'(pop);
    end
  end

endmodule

@@ src/peh_back.sv @@
// Back end: energy edge walk, histogram memories, clear sweep and read-out.
// Depends on peh_pkg.
`timescale 1ns / 1ps

module peh_back import peh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_pop,
  input  cmd_t      cmd,
  input  cfg_t      cfg,
  output logic      init_busy,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  typedef enum logic [10:0] {
    B_INIT  = 11'b00000000001,
    B_IDLE  = 11'b00000000010,
    B_CLEAR = 11'b00000000100,
    B_READ  = 11'b00000001000,
    B_RDW   = 11'b00000010000,
    B_WALK  = 11'b00000100000,
    B_LM0   = 11'b00001000000,
    B_LM1   = 11'b00010000000,
    B_LADD  = 11'b00100000000,
    B_RMW   = 11'b01000000000,
    B_INC   = 11'b10000000000
  } bstate_t;

  bstate_t           state;
  cmd_t              c;
  logic [CELL_W-1:0] addr;
  logic [63:0]       lo;
  logic [EBIN_W-1:0] k;
  logic              sel;
  logic [60:0]       p0;
  logic [59:0]       p1;
  out_item_t         wres, res;
  logic              res_valid;

  logic [31:0] e_mem [CELLS];
  logic [31:0] i_mem [CELLS];
  logic [31:0] e_rd, i_rd;

  logic [CELL_W-1:0] raddr, waddr;
  logic              sweep, e_we, i_we;
  logic [31:0]       cnt, inc;
  logic [63:0]       e, hi_walk, hi_log, hi;
  logic [64:0]       lin_sum;
  logic [65:0]       log_sum;
  logic              deciding, lo_miss, hit, last, miss, adv, start_mul, species_done;
  out_item_t         fin;

  assign sweep = (state == B_INIT) || (state == B_CLEAR);
  assign raddr = (state == B_READ) ? {c.read_position_bin[PBIN_W-1:0],
                                      c.read_energy_bin[EBIN_W-1:0]}
                                   : {c.pbin, k};
  assign waddr = sweep ? addr : {c.pbin, k};
  assign cnt   = sel ? i_rd : e_rd;
  assign inc   = (cnt == '1) ? cnt : cnt + 1'b1;
  assign e_we  = sweep || (state == B_INC && !sel);
  assign i_we  = sweep || (state == B_INC && sel);

  always_ff @(posedge clk) begin
    if (e_we) e_mem[waddr] <= sweep ? '0 : inc;
    e_rd <= e_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (i_we) i_mem[waddr] <= sweep ? '0 : inc;
    i_rd <= i_mem[raddr];
  end

  // edge candidates
  assign e       = {8'd0, sel ? c.i_energy : c.e_energy};
  assign lin_sum = {1'b0, lo} + {1'b0, cfg.energy_step};
  assign hi_walk = (cfg.log_mode || lin_sum[64]) ? '1 : lin_sum[63:0];
  assign log_sum = {1'b0, p1, 5'd0} + 66'(p0[60:24]);
  assign hi_log  = (log_sum[65:64] != 2'd0) ? '1 : log_sum[63:0];
  assign hi      = (state == B_LADD) ? hi_log : hi_walk;

  always_comb begin
    lo_miss   = (state == B_WALK) && (e < lo);
    start_mul = (state == B_WALK) && !lo_miss && cfg.log_mode && (lo <= EDGE_CAP);
    deciding  = ((state == B_WALK) && !lo_miss && !start_mul) || (state == B_LADD);
    last      = k == EBIN_W'(ENERGY_BINS - 1);
    hit       = deciding && (e < hi);
    miss      = lo_miss || (deciding && !hit && last);
    adv       = deciding && !hit && !last;
    species_done = miss || (state == B_INC);
    fin = wres;
    if (state == B_INC) begin
      if (sel) fin.ion_binned      = 1'b1;
      else     fin.electron_binned = 1'b1;
    end
  end

  assign q_pop        = (state == B_IDLE) && q_valid && !res_valid;
  assign init_busy    = state == B_INIT;
  assign result_valid = res_valid;
  assign result       = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_INIT;
      addr      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !result_stall) res_valid <= 1'b0;
      unique case (state)
        B_INIT: begin
          addr <= addr + 1'b1;
          if (addr == '1) state <= B_IDLE;
        end
        B_IDLE: begin
          if (q_pop) begin
            c    <= cmd;
            wres <= '0;
            sel  <= 1'b0;
            lo   <= cfg.energy_first_edge;
            k    <= '0;
            case (cmd.action)
              ACT_CLEAR: begin
                addr  <= '0;
                state <= B_CLEAR;
              end
              ACT_READ: state <= B_READ;
              ACT_BIN: begin
                if (cmd.outside) begin
                  // counts zero, outside flag set, both binned flags clear
                  res       <= {32'd0, 32'd0, 1'b1, 1'b0, 1'b0};
                  res_valid <= 1'b1;
                end else begin
                  state <= B_WALK;
                end
              end
              default: begin
                res       <= '0;
                res_valid <= 1'b1;
              end
            endcase
          end
        end
        B_CLEAR: begin
          addr <= addr + 1'b1;
          if (addr == '1) begin
            res       <= '0;
            res_valid <= 1'b1;
            state     <= B_IDLE;
          end
        end
        B_READ: state <= B_RDW;
        B_RDW: begin
          if (32'(c.read_position_bin) < 32'(POSITION_BINS) &&
              32'(c.read_energy_bin) < 32'(ENERGY_BINS)) begin
            res <= {e_rd, i_rd, 3'b000};
          end else begin
            res <= '0;
          end
          res_valid <= 1'b1;
          state     <= B_IDLE;
        end
        B_LM0: begin
          p0    <= 61'(lo[28:0]) * 61'(cfg.energy_ratio);
          state <= B_LM1;
        end
        B_LM1: begin
          p1    <= 60'(lo[56:29]) * 60'(cfg.energy_ratio);
          state <= B_LADD;
        end
        B_RMW: state <= B_INC;
        B_WALK, B_LADD, B_INC: begin
          if (start_mul) state <= B_LM0;
          if (hit)       state <= B_RMW;
          if (adv) begin
            lo    <= hi;
            k     <= k + 1'b1;
            state <= B_WALK;
          end
          if (species_done) begin
            if (!sel) begin
              wres  <= fin;
              sel   <= 1'b1;
              lo    <= cfg.energy_first_edge;
              k     <= '0;
              state <= B_WALK;
            end else begin
              res       <= fin;
              res_valid <= 1'b1;
              state     <= B_IDLE;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
